FILE: design/tpls_pkg.sv
package tpls_pkg;

  localparam int TablePoints = 16;
  localparam int IdxW = $clog2(TablePoints);

  localparam logic [1:0] ModeEval  = 2'd0;
  localparam logic [1:0] ModeGain  = 2'd1;
  localparam logic [1:0] ModePitch = 2'd2;
  localparam logic [1:0] ModeIdle  = 2'd3;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatSat  = 2'd2;
  localparam logic [1:0] StatIdx  = 2'd3;

  localparam logic [1:0] RegRatedPower = 2'd0;
  localparam logic [1:0] RegEfficiency = 2'd1;
  localparam logic [1:0] RegGainPoints = 2'd2;
  localparam logic [1:0] RegPitchPoints = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        derating_ratio;
    logic [15:0]        max_speed;
    logic [15:0]        measured_speed;
    logic [3:0]         point_index;
    logic [15:0]        point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        max_torque;
    logic [31:0]        below_rated_torque;
    logic signed [31:0] minimum_pitch;
    logic [1:0]         status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the item and clear the pipeline state
    logic div_start; // start the divider
    logic div_step;  // one divider iteration
    logic scan;      // one table scan step
    logic interp;    // store a quotient and move to the next phase
    logic mul;       // speed squared
    logic finish;    // gain product for the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic scan_done;
  } stat_t;

endpackage

FILE: design/tpls_datapath.sv
module tpls_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tpls_pkg::cmd_t      cmd,
  output tpls_pkg::stat_t     stat,
  input  tpls_pkg::in_item_t  item,
  input  logic [31:0]         rated_power,
  input  logic [15:0]         efficiency,
  input  logic [4:0]          gain_points,
  input  logic [4:0]          pitch_points,
  output tpls_pkg::out_item_t result
);
  import tpls_pkg::*;

  localparam int DivW = 64;
  localparam int CntW = $clog2(DivW + 1);

  logic [15:0]        gx [TablePoints];
  logic signed [31:0] gy [TablePoints];
  logic [15:0]        px [TablePoints];
  logic signed [31:0] py [TablePoints];

  in_item_t           it;
  logic [IdxW:0]      k;
  logic [IdxW:0]      gn, pn;
  logic               g_found, p_found;
  logic [IdxW-1:0]    gk, pk;
  logic               g_direct, p_direct;
  logic signed [31:0] g_val, p_val;

  // Interpolation operands: one shared signed-magnitude divide chain.
  logic [1:0]         phase; // 0 torque, 1 gain, 2 pitch
  logic [63:0]        dvd, quo, rem_r;
  logic [31:0]        dvs;
  logic [CntW-1:0]    cnt;
  logic               neg_q;
  logic [63:0]        torque_q;
  logic signed [63:0] g_res, p_res;
  logic [15:0]        d;
  logic [31:0]        s2;
  logic [63:0]        brt;
  logic [16:0]        rem_d;
  logic [48:0]        num_a;
  logic [31:0]        den;

  function automatic logic [IdxW:0] used(input logic [4:0] r);
    if (r == 5'd0) return (IdxW+1)'(1);
    if (32'(r) > TablePoints) return (IdxW+1)'(TablePoints);
    return (IdxW+1)'(r);
  endfunction

  // Table writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TablePoints; i++) begin
        gx[i] <= '0; gy[i] <= '0; px[i] <= '0; py[i] <= '0;
      end
    end else if (cmd.load && 32'(item.point_index) < TablePoints) begin
      if (item.mode == ModeGain) begin
        gx[item.point_index[IdxW-1:0]] <= item.point_x;
        gy[item.point_index[IdxW-1:0]] <= item.point_y;
      end else if (item.mode == ModePitch) begin
        px[item.point_index[IdxW-1:0]] <= item.point_x;
        py[item.point_index[IdxW-1:0]] <= item.point_y;
      end
    end
  end

  assign d = it.derating_ratio;
  assign stat.scan_done = (k == (IdxW+1)'(TablePoints));
  assign stat.div_done = (cnt == '0);

  // Torque divide operands.
  assign rem_d = (d > 16'd32768) ? 17'd0 : 17'd32768 - 17'(d);
  assign num_a = 49'(rem_d) * 49'(rated_power);
  assign den   = 32'(it.max_speed) * 32'(efficiency);

  // Divide operands for each phase.
  logic signed [32:0] dy;
  logic [15:0]        dx, tt;
  logic [IdxW-1:0]    sk;
  logic               is_p;
  logic [47:0]        prod_mag;
  logic signed [48:0] prod;

  assign is_p = (phase == 2'd2);
  assign sk   = is_p ? pk : gk;
  assign dx   = is_p ? px[sk] - px[sk-1'b1] : gx[sk] - gx[sk-1'b1];
  assign tt   = is_p ? d - px[sk-1'b1] : d - gx[sk-1'b1];
  assign dy   = is_p ? 33'(py[sk]) - 33'(py[sk-1'b1]) : 33'(gy[sk]) - 33'(gy[sk-1'b1]);
  assign prod = 49'(dy) * $signed({1'b0, tt});
  assign prod_mag = prod[48] ? 48'(-prod) : 48'(prod);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it       <= item;
      k        <= (IdxW+1)'(1);
      gn       <= used(gain_points);
      pn       <= used(pitch_points);
      g_found  <= 1'b0;
      p_found  <= 1'b0;
      gk       <= '0;
      pk       <= '0;
      g_direct <= 1'b0;
      p_direct <= 1'b0;
      cnt      <= '0;
      phase    <= 2'd0;
    end
    if (cmd.scan) begin
      if (k == (IdxW+1)'(1)) begin
        if (32'(d) <= 32'(gx[0])) begin g_found <= 1'b1; g_direct <= 1'b1; g_val <= gy[0]; end
        if (32'(d) <= 32'(px[0])) begin p_found <= 1'b1; p_direct <= 1'b1; p_val <= py[0]; end
      end
      if (k < (IdxW+1)'(TablePoints)) begin
        // The last scan step also closes a full table with the last ordinate.
        if (!g_found && !(k == (IdxW+1)'(1) && d <= gx[0])) begin
          if (k < gn && d <= gx[k[IdxW-1:0]]) begin
            g_found <= 1'b1; gk <= k[IdxW-1:0];
            g_direct <= (gx[k[IdxW-1:0]] <= gx[k[IdxW-1:0]-1'b1]);
            g_val <= gy[k[IdxW-1:0]];
          end else if (k >= gn || k == (IdxW+1)'(TablePoints - 1)) begin
            g_found <= 1'b1; g_direct <= 1'b1; g_val <= gy[gn[IdxW-1:0] - 1'b1];
          end
        end
        if (!p_found && !(k == (IdxW+1)'(1) && d <= px[0])) begin
          if (k < pn && d <= px[k[IdxW-1:0]]) begin
            p_found <= 1'b1; pk <= k[IdxW-1:0];
            p_direct <= (px[k[IdxW-1:0]] <= px[k[IdxW-1:0]-1'b1]);
            p_val <= py[k[IdxW-1:0]];
          end else if (k >= pn || k == (IdxW+1)'(TablePoints - 1)) begin
            p_found <= 1'b1; p_direct <= 1'b1; p_val <= py[pn[IdxW-1:0] - 1'b1];
          end
        end
        k <= k + 1'b1;
      end
    end
    if (cmd.div_start) begin
      // Torque quotient first; then the two interpolation quotients.
      if (phase == 2'd0) begin
        dvd   <= {7'd0, num_a, 8'd0};
        dvs   <= den;
        neg_q <= 1'b0;
        cnt   <= CntW'(DivW);
      end else if ((phase == 2'd1 && !g_direct) || (phase == 2'd2 && !p_direct)) begin
        dvd   <= 64'(prod_mag);
        dvs   <= 32'(dx);
        neg_q <= prod[48];
        cnt   <= CntW'(DivW);
      end
      quo   <= '0;
      rem_r <= '0;
    end
    if (cmd.div_step && cnt != '0) begin
      logic [64:0] r2;
      r2 = {rem_r, dvd[63]};
      dvd <= {dvd[62:0], 1'b0};
      if (r2 >= 65'(dvs)) begin
        rem_r <= 64'(r2 - 65'(dvs));
        quo   <= {quo[62:0], 1'b1};
      end else begin
        rem_r <= r2[63:0];
        quo   <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
    if (cmd.interp) begin
      // Store the quotient that just finished and move to the next phase.
      if (phase == 2'd0) torque_q <= quo;
      else if (phase == 2'd1)
        g_res <= g_direct ? 64'(g_val) : 64'(gy[gk-1'b1]) + (neg_q ? -$signed(quo) : $signed(quo));
      else
        p_res <= p_direct ? 64'(p_val) : 64'(py[pk-1'b1]) + (neg_q ? -$signed(quo) : $signed(quo));
      phase <= phase + 1'b1;
    end
    if (cmd.mul) s2 <= 32'(it.measured_speed) * 32'(it.measured_speed);
    if (cmd.finish) brt <= 64'(g_res[31:0]) * 64'(s2);
  end

  // Result forming from registered quantities.
  always_comb begin
    logic signed [31:0] g32;
    logic [1:0] st;
    g32 = g_res[31:0];
    result = '0;
    st = StatOk;
    if (it.mode == ModeGain || it.mode == ModePitch) begin
      if (32'(it.point_index) >= TablePoints) st = StatIdx;
    end else if (it.mode == ModeEval) begin
      if (it.max_speed == 16'd0) begin
        result.max_torque = '1; st = StatZero;
      end else if (efficiency == 16'd0) begin
        result.max_torque = '1; st = StatSat;
      end else begin
        if (d > 16'd32768) st = StatSat;
        if (torque_q[63:32] != '0) begin result.max_torque = '1; st = StatSat; end
        else result.max_torque = torque_q[31:0];
      end
      if (g32 < 0) begin
        if (s2 != '0 && st == StatOk) st = StatSat;
      end else result.below_rated_torque = brt[63:32];
      result.minimum_pitch = p_res[31:0];
    end
    result.status = st;
  end

endmodule

FILE: design/tpls_ctrl.sv
module tpls_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      mode,
  input  tpls_pkg::stat_t stat,
  output tpls_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import tpls_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_DSTRT = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_STORE = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_PROD  = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_LOAD  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [1:0] ph, ph_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ph <= '0;
    end else begin
      state <= state_next; ph <= ph_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    ph_next = ph;
    busy = (state != S_IDLE);
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          ph_next = '0;
          state_next = (mode == ModeEval) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: state_next = S_OUT;
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = S_DSTRT;
      end
      S_DSTRT: begin cmd.div_start = 1'b1; state_next = S_DIV; end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.interp = 1'b1;
        ph_next = ph + 1'b1;
        state_next = (ph == 2'd2) ? S_MUL : S_DSTRT;
      end
      S_MUL:  begin cmd.mul = 1'b1; state_next = S_PROD; end
      S_PROD: begin cmd.finish = 1'b1; state_next = S_OUT; end
      S_OUT:  begin done = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/turbine_power_limit_scheduler.sv
// Turbine power limit scheduler. An item is transferred when start is high
// and busy is low; its single result appears on result for exactly one cycle
// with done high, and the receiver cannot stall it. A load item writes its
// table point at the transfer and then passes through a load state and the
// result state. An evaluate item passes through the table scan, three passes
// through a shared 64-step radix-2 divider (torque and the two
// interpolations, each pass with a start and a store state), then the speed
// square, the gain product and the result state. A lookup that clamps or hits
// a segment of zero or negative width needs no divide, and its pass runs no
// divide steps.
module turbine_power_limit_scheduler (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tpls_pkg::in_item_t   item,
  output logic                 done,
  output tpls_pkg::out_item_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import tpls_pkg::*;

  logic [31:0] rated_power;
  logic [15:0] efficiency;
  logic [4:0]  gain_points, pitch_points;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_ready = 1'b1;

  // Configuration registers; the user must write them only while the block is idle (not enforced by the block).
  always_ff @(posedge clk) begin
    if (rst) begin
      rated_power  <= '0;
      efficiency   <= 16'd32768;
      gain_points  <= 5'd1;
      pitch_points <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegRatedPower:  rated_power  <= cfg_data;
        RegEfficiency:  efficiency   <= cfg_data[15:0];
        RegGainPoints:  gain_points  <= cfg_data[4:0];
        RegPitchPoints: pitch_points <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  tpls_ctrl u_ctrl (
    .clk, .rst, .start, .mode(item.mode), .stat, .cmd, .busy, .done
  );

  tpls_datapath u_dp (
    .clk, .rst, .cmd, .stat, .item, .rated_power, .efficiency,
    .gain_points, .pitch_points, .result
  );

  // A result is only shown while the controller is still busy.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside busy");
  // A transferred item always leads to busy in the next cycle.
  a_start: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("start not taken");
  // After done, the block returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("not idle after done");

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpls_pkg::*;

  // The run is stopped at this many cycles. About 1500 items are sent, with
  // idle gaps from the sender between some of them, so this leaves several
  // times the slowest correct run.
  localparam int unsigned CycleLimit = 3000000;
  localparam int PhaseCount = 6;
  localparam int ItemsPerPhase = 250;
  localparam int DirectedCount = 22;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      done;
  out_item_t result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  turbine_power_limit_scheduler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The testbench keeps its own copy of the registers and of both tables.
  // They are updated when a transfer is accepted, so the expected result of
  // each item always sees the state that the block saw.
  logic [31:0] rated_power_q;
  logic [15:0] efficiency_q;
  logic [4:0]  gain_count_q;
  logic [4:0]  pitch_count_q;
  logic [15:0] gain_x [TablePoints];
  logic signed [31:0] gain_y [TablePoints];
  logic [15:0] pitch_x [TablePoints];
  logic signed [31:0] pitch_y [TablePoints];

  // Expected results, oldest first.
  out_item_t pending_limits[$];
  int unsigned mismatches;
  int unsigned cycles;
  int idle_pct;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  directed_row_t directed [DirectedCount];

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // A register count of zero means one point; anything above the table size
  // means the whole table.
  function automatic int unsigned points_in_use(logic [4:0] count);
    if (count == 5'd0) return 1;
    if (count > TablePoints) return TablePoints;
    return count;
  endfunction

  // Piecewise-linear lookup, clamped at both ends. The segment used ends at
  // the first point at or beyond x; a segment whose width is zero or negative
  // gives the ordinate of its end point.
  function automatic logic signed [31:0] interpolate(bit pitch_table, int unsigned n,
                                                     logic [15:0] x);
    logic [15:0] xs [TablePoints];
    logic signed [31:0] ys [TablePoints];
    longint dx;
    longint dt;
    longint dy;
    for (int i = 0; i < TablePoints; i++) begin
      xs[i] = pitch_table ? pitch_x[i] : gain_x[i];
      ys[i] = pitch_table ? pitch_y[i] : gain_y[i];
    end
    if (x <= xs[0]) return ys[0];
    for (int k = 1; k < n; k++) begin
      if (x <= xs[k]) begin
        dx = longint'(xs[k]) - longint'(xs[k-1]);
        if (dx <= 0) return ys[k];
        dt = longint'(x) - longint'(xs[k-1]);
        dy = longint'(ys[k]) - longint'(ys[k-1]);
        return 32'(longint'(ys[k-1]) + (dy * dt) / dx);
      end
    end
    return ys[n-1];
  endfunction

  // Works out the result of one item and applies its table write.
  function automatic out_item_t predict_limits(in_item_t x);
    out_item_t r;
    logic [63:0] headroom;
    logic [63:0] quotient;
    logic [63:0] speed_sq;
    logic [63:0] product;
    logic signed [31:0] gain;
    r = '0;
    r.status = StatOk;
    if (x.mode == ModeGain || x.mode == ModePitch) begin
      // The index field cannot reach the table size, so every load writes.
      if (x.mode == ModeGain) begin
        gain_x[x.point_index] = x.point_x;
        gain_y[x.point_index] = x.point_y;
      end else begin
        pitch_x[x.point_index] = x.point_x;
        pitch_y[x.point_index] = x.point_y;
      end
      return r;
    end
    if (x.mode != ModeEval) return r;

    if (x.max_speed == 16'd0) begin
      r.max_torque = '1;
      r.status = StatZero;
    end else if (efficiency_q == 16'd0) begin
      r.max_torque = '1;
      r.status = StatSat;
    end else begin
      headroom = 64'd0;
      if (x.derating_ratio > 16'd32768) r.status = StatSat;
      else headroom = 64'd32768 - 64'(x.derating_ratio);
      quotient = (headroom * 64'(rated_power_q) * 64'd256) /
                 (64'(x.max_speed) * 64'(efficiency_q));
      if (quotient > 64'hFFFF_FFFF) begin
        quotient = 64'hFFFF_FFFF;
        r.status = StatSat;
      end
      r.max_torque = quotient[31:0];
    end

    speed_sq = 64'(x.measured_speed) * 64'(x.measured_speed);
    gain = interpolate(1'b0, points_in_use(gain_count_q), x.derating_ratio);
    if (gain < 0) begin
      r.below_rated_torque = '0;
      if (speed_sq != 0 && r.status == StatOk) r.status = StatSat;
    end else begin
      product = (64'(unsigned'(gain)) * speed_sq) >> 32;
      if (product > 64'hFFFF_FFFF) begin
        product = 64'hFFFF_FFFF;
        if (r.status == StatOk) r.status = StatSat;
      end
      r.below_rated_torque = product[31:0];
    end

    r.minimum_pitch = interpolate(1'b1, points_in_use(pitch_count_q), x.derating_ratio);
    return r;
  endfunction

  function automatic in_item_t make_item(logic [1:0] mode, logic [15:0] ratio,
                                         logic [15:0] wmax, logic [15:0] wmeas,
                                         logic [3:0] idx, logic [15:0] px,
                                         logic [31:0] py);
    in_item_t x;
    x.mode = mode;
    x.derating_ratio = ratio;
    x.max_speed = wmax;
    x.measured_speed = wmeas;
    x.point_index = idx;
    x.point_x = px;
    x.point_y = py;
    return x;
  endfunction

  // Most loads build a rising table so that interpolation is exercised across
  // real segments; the rest scatter the abscissas anywhere in the field.
  function automatic in_item_t random_item();
    in_item_t x;
    int unsigned pick;
    x = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      x.mode = ModeEval;
      x.derating_ratio = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 32768))
                                                   : 16'($urandom);
      if ($urandom_range(0, 19) == 0) x.max_speed = 16'd0;
      else if ($urandom_range(0, 9) == 0) x.max_speed = 16'($urandom_range(1, 8));
    end else if (pick < 96) begin
      x.mode = (pick < 70) ? ModeGain : ModePitch;
      if ($urandom_range(0, 9) < 7)
        x.point_x = 16'(x.point_index * 2184 + $urandom_range(0, 2000));
      else if ($urandom_range(0, 1) == 1)
        x.point_x = 16'($urandom_range(0, 32768));
      if ($urandom_range(0, 3) == 0) x.point_y = 32'($signed($urandom_range(0, 65535)) - 32768);
    end else begin
      x.mode = ModeIdle;
    end
    return x;
  endfunction

  // Register writes happen only while nothing is in flight.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegRatedPower:  rated_power_q = value;
      RegEfficiency:  efficiency_q = value[15:0];
      RegGainPoints:  gain_count_q = value[4:0];
      default:        pitch_count_q = value[4:0];
    endcase
  endtask

  task automatic wait_until_drained();
    while (pending_limits.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds start high until the transfer is taken, then records what should
  // come back. A typed expectation replaces the predicted one, but the
  // predictor still runs so that its tables follow any load.
  task automatic send_item(in_item_t x, bit typed, out_item_t want);
    out_item_t predicted;
    start <= 1'b1;
    item <= x;
    do @(posedge clk); while (busy);
    predicted = predict_limits(x);
    pending_limits.push_back(typed ? want : predicted);
  endtask

  // Between items the sender sometimes idles; start is only lowered when a
  // gap actually follows, so it is never dropped and raised in one step.
  task automatic sender_gap();
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_limits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = pending_limits.pop_front();
        if (result.max_torque !== want.max_torque ||
            result.below_rated_torque !== want.below_rated_torque ||
            result.minimum_pitch !== want.minimum_pitch ||
            result.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: torque %h/%h brt %h/%h pitch %h/%h status %0d/%0d (exp/got)",
                     want.max_torque, result.max_torque,
                     want.below_rated_torque, result.below_rated_torque,
                     want.minimum_pitch, result.minimum_pitch,
                     want.status, result.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_item_t none;
    out_item_t t;
    in_item_t x;
    logic [31:0] power;
    logic [15:0] eff;
    logic [4:0]  gain_n;
    logic [4:0]  pitch_n;

    none = '0;
    mismatches = 0;
    cycles = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = RegRatedPower;
    cfg_data = '0;

    // Reset state of the predictor.
    rated_power_q = '0;
    efficiency_q = 16'd32768;
    gain_count_q = 5'd1;
    pitch_count_q = 5'd1;
    for (int i = 0; i < TablePoints; i++) begin
      gain_x[i] = '0;
      gain_y[i] = '0;
      pitch_x[i] = '0;
      pitch_y[i] = '0;
    end

    // Directed rows. The first four are read straight off the spec: zero
    // max speed right after reset, an ignored mode, and two plain loads.
    // The rest load short tables and evaluate at the field extremes,
    // and are checked against the predictor.
    t = '1;
    t.below_rated_torque = '0;
    t.minimum_pitch = '0;
    t.status = StatZero;
    directed[0] = '{make_item(ModeEval, 16'd0, 16'd0, 16'hFFFF, 4'd0, 16'd0, 32'd0), 1'b1, t};
    t = '0;
    t.status = StatOk;
    directed[1] = '{make_item(ModeIdle, '1, '1, '1, '1, '1, '1), 1'b1, t};
    directed[2] = '{make_item(ModeGain, 16'd0, 16'd0, 16'd0, 4'd15, 16'd32768, 32'h7FFF_FFFF),
                    1'b1, t};
    directed[3] = '{make_item(ModePitch, '1, '1, '1, 4'd0, 16'd0, 32'h8000_0000), 1'b1, t};
    directed[4] = '{make_item(ModeGain, 0, 0, 0, 4'd0, 16'd0, 32'h0001_0000), 1'b0, none};
    directed[5] = '{make_item(ModeGain, 0, 0, 0, 4'd1, 16'd16384, 32'h0004_0000), 1'b0, none};
    directed[6] = '{make_item(ModeGain, 0, 0, 0, 4'd2, 16'd16384, 32'hFFFF_0000), 1'b0, none};
    directed[7] = '{make_item(ModeGain, 0, 0, 0, 4'd3, 16'd32768, 32'h7FFF_FFFF), 1'b0, none};
    directed[8] = '{make_item(ModePitch, 0, 0, 0, 4'd1, 16'd8192, 32'h0000_8000), 1'b0, none};
    directed[9] = '{make_item(ModePitch, 0, 0, 0, 4'd2, 16'd4096, 32'h0002_0000), 1'b0, none};
    directed[10] = '{make_item(ModePitch, 0, 0, 0, 4'd3, 16'd32768, 32'h7FFF_FFFF), 1'b0, none};
    directed[11] = '{make_item(ModeEval, 16'd0, 16'd1, 16'hFFFF, 0, 0, 0), 1'b0, none};
    directed[12] = '{make_item(ModeEval, 16'd8192, 16'hFFFF, 16'h0100, 0, 0, 0), 1'b0, none};
    directed[13] = '{make_item(ModeEval, 16'd16384, 16'h1000, 16'hFFFF, 0, 0, 0), 1'b0, none};
    directed[14] = '{make_item(ModeEval, 16'd20000, 16'h2000, 16'h0000, 0, 0, 0), 1'b0, none};
    directed[15] = '{make_item(ModeEval, 16'd20000, 16'h2000, 16'h0001, 0, 0, 0), 1'b0, none};
    directed[16] = '{make_item(ModeEval, 16'd32768, 16'h3000, 16'h8000, 0, 0, 0), 1'b0, none};
    directed[17] = '{make_item(ModeEval, 16'd32769, 16'h3000, 16'h8000, 0, 0, 0), 1'b0, none};
    directed[18] = '{make_item(ModeEval, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0), 1'b0, none};
    directed[19] = '{make_item(ModeEval, 16'd6000, 16'd0, 16'h4000, 0, 0, 0), 1'b0, none};
    directed[20] = '{make_item(ModeEval, 16'd1, 16'h0001, 16'h0001, 0, 0, 0), 1'b0, none};
    directed[21] = '{make_item(ModeEval, 16'd12000, 16'h8000, 16'h2000, 0, 0, 0), 1'b0, none};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first rows run on the reset configuration; the tables are then
    // widened and full scale power set before the extremes are evaluated.
    for (int i = 0; i < DirectedCount; i++) begin
      if (i == 4) begin
        start <= 1'b0;
        wait_until_drained();
        write_register(RegRatedPower, 32'hFFFF_FFFF);
        write_register(RegGainPoints, 32'd4);
        write_register(RegPitchPoints, 32'd4);
      end
      send_item(directed[i].stim, directed[i].typed, directed[i].want);
    end
    start <= 1'b0;

    // Random phases: sender idles 17 percent, then 48, then never. Each
    // phase starts from idle with a new configuration, extremes first.
    for (int p = 0; p < PhaseCount; p++) begin
      idle_pct = (p < 2) ? 17 : (p < 4) ? 48 : 0;
      start <= 1'b0;
      wait_until_drained();
      power = $urandom;
      eff = 16'($urandom_range(1, 32768));
      gain_n = 5'($urandom_range(0, 31));
      pitch_n = 5'($urandom_range(0, 31));
      case (p)
        0: begin power = '0; eff = 16'd1; gain_n = 5'd0; pitch_n = 5'd31; end
        1: begin power = '1; eff = 16'hFFFF; gain_n = 5'd16; pitch_n = 5'd1; end
        2: begin eff = 16'd0; end
        3: begin power = 32'($urandom_range(0, 65535)); eff = 16'd32768; end
        default: ;
      endcase
      write_register(RegRatedPower, power);
      write_register(RegEfficiency, {16'd0, eff});
      write_register(RegGainPoints, {27'd0, gain_n});
      write_register(RegPitchPoints, {27'd0, pitch_n});
      for (int n = 0; n < ItemsPerPhase; n++) begin
        x = random_item();
        send_item(x, 1'b0, none);
        // Now and then the sender waits for every outstanding result.
        if ($urandom_range(0, 99) == 0) begin
          start <= 1'b0;
          wait_until_drained();
        end else begin
          sender_gap();
        end
      end
    end
    start <= 1'b0;

    wait_until_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_limits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: turbine_power_limit_scheduler.f
design/tpls_pkg.sv
design/tpls_datapath.sv
design/tpls_ctrl.sv
design/turbine_power_limit_scheduler.sv
tb/tb_top.sv
